@@ src/tjq_pkg.sv @@
// Package for the touch joystick direction quantizer.
// Holds widths, codes, state and register types and the per-axis helper functions.
// No dependencies; every other file of the block imports it.
package tjq_pkg;

  localparam int CoordW   = 12;
  localparam int IdW      = 8;
  localparam int OpW      = 2;
  localparam int DzW      = 8;
  localparam int OffW     = 14;
  localparam int RawW     = 15;
  localparam int StickW   = 13;
  localparam int AnaW     = 16;
  localparam int DigW     = 2;
  localparam int MulW     = 24;
  localparam int ProdW    = 2 * MulW;
  localparam int DiffW    = MulW + 3;
  localparam int QuotW    = 15;
  localparam int MulCntW  = $clog2(MulW);
  localparam int DivCntW  = $clog2(QuotW);
  localparam int AddrW    = 5;
  localparam int RegIdxW  = AddrW - 2;
  localparam int DataW    = 32;
  localparam int InDataW  = 32;
  localparam int OutDataW = 72;

  localparam logic [StickW-1:0] StickMax   = 13'd8190;
  localparam logic [AnaW-1:0]   AnaPosFull = 16'h7fff;
  localparam logic [AnaW-1:0]   AnaNegFull = 16'h8000;

  localparam logic [DigW-1:0] DIG_ZERO = 2'b00;
  localparam logic [DigW-1:0] DIG_POS  = 2'b01;
  localparam logic [DigW-1:0] DIG_NEG  = 2'b11;

  localparam logic [CoordW-1:0] PadLeftRst   = 12'd0;
  localparam logic [CoordW-1:0] PadTopRst    = 12'd0;
  localparam logic [CoordW-1:0] PadWidthRst  = 12'd100;
  localparam logic [CoordW-1:0] PadHeightRst = 12'd100;
  localparam logic [DzW-1:0]    DeadZoneRst  = 8'd10;

  typedef enum logic [OpW-1:0] {
    OP_BEGAN,
    OP_MOVED,
    OP_ENDED,
    OP_CANCELLED
  } tjq_op_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_PAD_LEFT,
    REG_PAD_TOP,
    REG_PAD_WIDTH,
    REG_PAD_HEIGHT,
    REG_DEAD_ZONE
  } tjq_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFS,
    S_UPD,
    S_LOAD,
    S_SQ,
    S_QUAD,
    S_DSQ,
    S_OUT
  } tjq_state_t;

  typedef struct packed {
    logic             ovf;
    logic [QuotW-1:0] quot;
  } tjq_div_res_t;

  // Dead zone forces zero, then the component is clamped to the pad size.
  function automatic logic [OffW-1:0] clamp_axis(input logic signed [RawW-1:0] raw,
                                                 input logic [CoordW-1:0] size,
                                                 input logic in_dz);
    logic signed [RawW-1:0] lim;
    logic signed [RawW-1:0] v;
    lim = signed'({{(RawW-CoordW){1'b0}}, size});
    v   = in_dz ? '0 : raw;
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v[OffW-1:0];
  endfunction

  function automatic logic [StickW-1:0] stick_pos(input logic [CoordW-1:0] size,
                                                  input logic [OffW-1:0] off);
    logic signed [RawW-1:0] s;
    s = signed'({{(RawW-CoordW){1'b0}}, size}) + signed'({off[OffW-1], off});
    if (s[RawW-1]) begin
      return '0;
    end else if (s[RawW-2:0] > {1'b0, StickMax}) begin
      return StickMax;
    end
    return s[StickW-1:0];
  endfunction

  function automatic logic [AnaW-1:0] analog_val(input logic [CoordW-1:0] size,
                                                 input logic neg,
                                                 input tjq_div_res_t res);
    logic [AnaW-1:0] q;
    q = {1'b0, res.quot};
    if (size == '0) begin
      return '0;
    end else if (res.ovf) begin
      return neg ? AnaNegFull : AnaPosFull;
    end
    return neg ? (~q + 1'b1) : q;
  endfunction

  // Sector test: c^2*(4+2*sqrt2) > c^2+o^2, with d = o^2 - 3*c^2.
  function automatic logic [DigW-1:0] digital_dir(input logic nonzero,
                                                  input logic neg,
                                                  input logic d_neg,
                                                  input logic [ProdW-1:0] c4,
                                                  input logic [ProdW-1:0] dsq);
    logic active;
    active = nonzero && (d_neg || ({c4, 3'b000} > {3'b000, dsq}));
    if (!active) begin
      return DIG_ZERO;
    end
    return neg ? DIG_NEG : DIG_POS;
  endfunction

endpackage

@@ src/touch_joystick_direction_quantizer.sv @@
// Top level of the touch joystick direction quantizer: ownership, offsets, output register.
// Uses tjq_pkg, two tjq_ser_mul units for the sector test and two tjq_ser_div units.
//
//   Port group | Dir | Payload
//   in_        | in  | tuser: op; tdata: touch_id, point_x, point_y
//   out_       | out | tuser: accepted; tdata: owner, stick, analog and digital per axis
//   cfg_       | in  | APB registers pad_left, pad_top, pad_width, pad_height, dead_zone
//
// The next input transfer can occur only once an item is through: three passes of the serial
// multipliers (a load and then the shift-and-add steps, for squares, fourth powers and
// squared differences) plus the control states S_IDLE, S_OFFS, S_UPD, S_LOAD and S_OUT.
// The dividers run alongside the first pass.
// Reset is synchronous and clears ownership, offsets, registers and the result buffer's valid flag.
// A result waiting for out_tready does not block the next input transfer; that item waits
// in its last cycle until the earlier result has left.
module touch_joystick_direction_quantizer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tjq_pkg::InDataW-1:0]  in_tdata,  // touch_id, point_x, point_y
  input  logic [tjq_pkg::OpW-1:0]      in_tuser,  // op
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tjq_pkg::OutDataW-1:0] out_tdata, // owner, stick_x, stick_y, analog_x,
                                                  // analog_y, digital_x, digital_y
  output logic                         out_tuser, // accepted
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tjq_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [tjq_pkg::DataW-1:0]    cfg_pwdata,
  output logic [tjq_pkg::DataW-1:0]    cfg_prdata,
  output logic                         cfg_pready
);
  import tjq_pkg::*;

  logic [CoordW-1:0] pad_left_r, pad_top_r, pad_width_r, pad_height_r;
  logic [DzW-1:0]    dead_zone_r;
  logic              cfg_wr;
  tjq_reg_t          cfg_idx;

  tjq_state_t state_r, state_nxt;
  logic cap_in, calc_raw, upd, start_p1, start_p2, start_p3, load_out;

  tjq_op_t           op_r;
  logic [IdW-1:0]    tid_r;
  logic [CoordW-1:0] px_r, py_r;

  logic signed [RawW-1:0] raw_x_r, raw_y_r, raw_x_nxt, raw_y_nxt;
  logic signed [RawW-1:0] dz_pos, dz_neg;
  logic                   in_dz;

  logic [IdW-1:0]  owner_r, owner_tmp;
  logic [OffW-1:0] off_x_r, off_y_r;
  logic            acc_r, acc_now, release_now;

  logic [OffW-1:0]  mag_x, mag_y;
  logic             mul_start;
  logic [MulW-1:0]  mul0_op, mul1_op;
  logic [ProdW-1:0] prod0, prod1;
  logic             mul0_done, mul1_done;
  logic [DiffW-1:0] dx_full, dy_full;
  logic [MulW-1:0]  dx_r, dy_r;
  logic             dx_neg_r, dy_neg_r;
  logic [ProdW-1:0] x4_r, y4_r;
  tjq_div_res_t     div_x, div_y;

  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                out_user_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = tjq_reg_t'(cfg_paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_left_r   <= PadLeftRst;
      pad_top_r    <= PadTopRst;
      pad_width_r  <= PadWidthRst;
      pad_height_r <= PadHeightRst;
      dead_zone_r  <= DeadZoneRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PAD_LEFT:   pad_left_r   <= cfg_pwdata[CoordW-1:0];
        REG_PAD_TOP:    pad_top_r    <= cfg_pwdata[CoordW-1:0];
        REG_PAD_WIDTH:  pad_width_r  <= cfg_pwdata[CoordW-1:0];
        REG_PAD_HEIGHT: pad_height_r <= cfg_pwdata[CoordW-1:0];
        REG_DEAD_ZONE:  dead_zone_r  <= cfg_pwdata[DzW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PAD_LEFT:   cfg_prdata = {{(DataW-CoordW){1'b0}}, pad_left_r};
      REG_PAD_TOP:    cfg_prdata = {{(DataW-CoordW){1'b0}}, pad_top_r};
      REG_PAD_WIDTH:  cfg_prdata = {{(DataW-CoordW){1'b0}}, pad_width_r};
      REG_PAD_HEIGHT: cfg_prdata = {{(DataW-CoordW){1'b0}}, pad_height_r};
      REG_DEAD_ZONE:  cfg_prdata = {{(DataW-DzW){1'b0}}, dead_zone_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_OFFS;
      S_OFFS: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SQ;
      S_SQ:   if (mul0_done) state_nxt = S_QUAD;
      S_QUAD: if (mul0_done) state_nxt = S_DSQ;
      S_DSQ:  if (mul0_done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    calc_raw  = 1'b0;
    upd       = 1'b0;
    start_p1  = 1'b0;
    start_p2  = 1'b0;
    start_p3  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_OFFS: calc_raw  = 1'b1;
      S_UPD:  upd       = 1'b1;
      S_LOAD: start_p1  = 1'b1;
      S_SQ:   start_p2  = mul0_done;
      S_QUAD: start_p3  = mul0_done;
      S_DSQ:  ;
      S_OUT:  load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign cap_in = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input capture and raw offsets in half-pixel units.
  always_ff @(posedge clk) begin
    if (cap_in) begin
      op_r  <= tjq_op_t'(in_tuser);
      tid_r <= in_tdata[IdW-1:0];
      px_r  <= in_tdata[IdW+CoordW-1:IdW];
      py_r  <= in_tdata[IdW+2*CoordW-1:IdW+CoordW];
    end
    if (calc_raw) begin
      raw_x_r <= raw_x_nxt;
      raw_y_r <= raw_y_nxt;
    end
  end

  assign raw_x_nxt = signed'({2'b00, px_r, 1'b0}) - signed'({2'b00, pad_left_r, 1'b0})
                     - signed'({{(RawW-CoordW){1'b0}}, pad_width_r});
  assign raw_y_nxt = signed'({2'b00, py_r, 1'b0}) - signed'({2'b00, pad_top_r, 1'b0})
                     - signed'({{(RawW-CoordW){1'b0}}, pad_height_r});

  // Ownership and stick state.
  assign dz_pos = signed'({{(RawW-DzW-1){1'b0}}, dead_zone_r, 1'b0});
  assign dz_neg = -dz_pos;
  assign in_dz  = (raw_x_r < dz_pos) && (raw_x_r > dz_neg)
                  && (raw_y_r < dz_pos) && (raw_y_r > dz_neg);

  assign owner_tmp   = (owner_r == '0 && op_r == OP_BEGAN && tid_r != '0) ? tid_r : owner_r;
  assign acc_now     = (tid_r != '0) && (tid_r == owner_tmp);
  assign release_now = (op_r == OP_ENDED) || (op_r == OP_CANCELLED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      off_x_r <= '0;
      off_y_r <= '0;
      acc_r   <= 1'b0;
    end else if (upd) begin
      acc_r <= acc_now;
      if (acc_now && release_now) begin
        owner_r <= '0;
        off_x_r <= '0;
        off_y_r <= '0;
      end else begin
        owner_r <= owner_tmp;
        if (acc_now) begin
          off_x_r <= clamp_axis(raw_x_r, pad_width_r, in_dz);
          off_y_r <= clamp_axis(raw_y_r, pad_height_r, in_dz);
        end
      end
    end
  end

  // Serial arithmetic.
  assign mag_x = off_x_r[OffW-1] ? (~off_x_r + 1'b1) : off_x_r;
  assign mag_y = off_y_r[OffW-1] ? (~off_y_r + 1'b1) : off_y_r;

  assign mul_start = start_p1 || start_p2 || start_p3;

  always_comb begin
    if (start_p1) begin
      mul0_op = {{(MulW-CoordW){1'b0}}, mag_x[CoordW-1:0]};
      mul1_op = {{(MulW-CoordW){1'b0}}, mag_y[CoordW-1:0]};
    end else if (start_p2) begin
      mul0_op = prod0[MulW-1:0];
      mul1_op = prod1[MulW-1:0];
    end else begin
      mul0_op = dx_r;
      mul1_op = dy_r;
    end
  end

  tjq_ser_mul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul0_op),
    .b     (mul0_op),
    .prod  (prod0),
    .done  (mul0_done)
  );

  tjq_ser_mul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul1_op),
    .b     (mul1_op),
    .prod  (prod1),
    .done  (mul1_done)
  );

  tjq_ser_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_p1),
    .mag   (mag_x[CoordW-1:0]),
    .size  (pad_width_r),
    .res   (div_x)
  );

  tjq_ser_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_p1),
    .mag   (mag_y[CoordW-1:0]),
    .size  (pad_height_r),
    .res   (div_y)
  );

  assign dx_full = {3'b000, prod1[MulW-1:0]}
                   - ({3'b000, prod0[MulW-1:0]} + {2'b00, prod0[MulW-1:0], 1'b0});
  assign dy_full = {3'b000, prod0[MulW-1:0]}
                   - ({3'b000, prod1[MulW-1:0]} + {2'b00, prod1[MulW-1:0], 1'b0});

  always_ff @(posedge clk) begin
    if (start_p2) begin
      dx_r     <= dx_full[MulW-1:0];
      dy_r     <= dy_full[MulW-1:0];
      dx_neg_r <= dx_full[DiffW-1];
      dy_neg_r <= dy_full[DiffW-1];
    end
    if (start_p3 && mul1_done) begin
      x4_r <= prod0;
      y4_r <= prod1;
    end
  end

  // Result buffer.
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[IdW-1:0] = owner_r;
    out_data_nxt[IdW+StickW-1:IdW] = stick_pos(pad_width_r, off_x_r);
    out_data_nxt[IdW+2*StickW-1:IdW+StickW] = stick_pos(pad_height_r, off_y_r);
    out_data_nxt[IdW+2*StickW+AnaW-1:IdW+2*StickW] =
      analog_val(pad_width_r, off_x_r[OffW-1], div_x);
    out_data_nxt[IdW+2*StickW+2*AnaW-1:IdW+2*StickW+AnaW] =
      analog_val(pad_height_r, off_y_r[OffW-1], div_y);
    out_data_nxt[IdW+2*StickW+2*AnaW+DigW-1:IdW+2*StickW+2*AnaW] =
      digital_dir(off_x_r != '0, off_x_r[OffW-1], dx_neg_r, x4_r, prod0);
    out_data_nxt[IdW+2*StickW+2*AnaW+2*DigW-1:IdW+2*StickW+2*AnaW+DigW] =
      digital_dir(off_y_r != '0, off_y_r[OffW-1], dy_neg_r, y4_r, prod1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ src/tjq_ser_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, unsigned.
// Depends on tjq_pkg for the operand and counter widths.
module tjq_ser_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tjq_pkg::MulW-1:0]  a,
  input  logic [tjq_pkg::MulW-1:0]  b,
  output logic [tjq_pkg::ProdW-1:0] prod,
  output logic                     done
);
  import tjq_pkg::*;

  logic [ProdW-1:0]   a_r, a_nxt;
  logic [MulW-1:0]    b_r, b_nxt;
  logic [ProdW-1:0]   acc_r, acc_nxt;
  logic [MulCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = {{(ProdW-MulW){1'b0}}, a};
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MulCntW'(MulW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

@@ src/tjq_ser_div.sv @@
// Restoring divider for the analog value: (mag << 15) / size, one quotient bit per cycle.
// Flags overflow when mag is not below size. Depends on tjq_pkg.
module tjq_ser_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tjq_pkg::CoordW-1:0] mag,
  input  logic [tjq_pkg::CoordW-1:0] size,
  output tjq_pkg::tjq_div_res_t      res
);
  import tjq_pkg::*;

  logic [CoordW-1:0]  rem_r, rem_nxt;
  logic [QuotW-1:0]   quot_r, quot_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [CoordW:0]    trial;

  assign trial = {rem_r, 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      ovf_nxt  = (mag >= size);
      rem_nxt  = mag;
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = (mag < size);
    end else if (busy_r) begin
      if (trial >= {1'b0, size}) begin
        rem_nxt  = CoordW'(trial - {1'b0, size});
        quot_nxt = {quot_r[QuotW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[CoordW-1:0];
        quot_nxt = {quot_r[QuotW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DivCntW'(QuotW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule

@@ src/tjq_checker.sv @@
// Port-level checker for the touch joystick direction quantizer, attached by bind.
// Depends on tjq_pkg and on the top level's port list.
module tjq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tjq_pkg::OutDataW-1:0] out_tdata,
  input logic                         out_tuser
);
  import tjq_pkg::*;

  localparam int StickXLo = IdW;
  localparam int StickYLo = IdW + StickW;
  localparam int DigXLo   = IdW + 2 * StickW + 2 * AnaW;
  localparam int DigYLo   = DigXLo + DigW;

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item at a time: an input transfer closes the input side for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[StickXLo+StickW-1:StickXLo] <= StickMax)
                   && (out_tdata[StickYLo+StickW-1:StickYLo] <= StickMax))
    else $error("stick position beyond pad");

  a_dig_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DigXLo+DigW-1:DigXLo] == DIG_ZERO
                    || out_tdata[DigXLo+DigW-1:DigXLo] == DIG_POS
                    || out_tdata[DigXLo+DigW-1:DigXLo] == DIG_NEG)
                   && (out_tdata[DigYLo+DigW-1:DigYLo] == DIG_ZERO
                    || out_tdata[DigYLo+DigW-1:DigYLo] == DIG_POS
                    || out_tdata[DigYLo+DigW-1:DigYLo] == DIG_NEG))
    else $error("invalid direction code");

endmodule

bind touch_joystick_direction_quantizer tjq_checker u_tjq_checker (.*);
